// ===== rtl/case_insensitive_pattern_matcher_top_assert.svh =====
// Assertion shorthands for the pattern matcher checker.
`ifndef CASE_INSENSITIVE_PATTERN_MATCHER_TOP_ASSERT_SVH
`define CASE_INSENSITIVE_PATTERN_MATCHER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define CIPM_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("cipm: assertion failed");

// Next-cycle implication, disabled while in reset.
`define CIPM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("cipm: assertion failed");

`endif

// ===== rtl/cipm_pkg.sv =====
package cipm_pkg;

  localparam int unsigned MaxPatternDef = 64;
  localparam int unsigned ByteW         = 8;
  localparam int unsigned SlotW         = 6;
  localparam int unsigned LenW          = 7;
  localparam int unsigned PosW          = 32;

  localparam logic [PosW-1:0] PosMax = '1;
  localparam logic [LenW-1:0] LenRst = LenW'(1);

  localparam logic KindPattern = 1'b0;
  localparam logic KindText    = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [SlotW-1:0] slot;
    logic [ByteW-1:0] byte_value;
    logic             restart;
  } in_item_t;

  typedef struct packed {
    logic [PosW-1:0] match_start;
    logic [PosW-1:0] occurrence_count;
  } out_item_t;

  typedef struct packed {
    logic step;
    logic pat_we;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_REPLAY = 2'b10
  } state_e;

  function automatic logic [ByteW-1:0] fold_upper(input logic [ByteW-1:0] b);
    logic [ByteW-1:0] r;
    r = b;
    if (b >= 8'h61 && b <= 8'h7A) begin
      r = b - 8'h20;
    end
    return r;
  endfunction

endpackage

// ===== rtl/cipm_cell.sv =====
// One pattern position: its pattern byte, one text byte of the history line
// and the prefix-match flag (text so far ends in pattern[0..k]).
module cipm_cell import cipm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_ctrl_t       ctrl_i,
  input  logic [ByteW-1:0] txt_i,
  input  logic [ByteW-1:0] cmp_i,
  input  logic [ByteW-1:0] pat_i,
  input  logic             flag_i,
  output logic [ByteW-1:0] txt_o,
  output logic             flag_o,
  output logic             hit_o
);

  logic [ByteW-1:0] pat_q;
  logic [ByteW-1:0] txt_q;
  logic             flag_q, flag_d;

  assign hit_o  = flag_i & (cmp_i == pat_q);
  assign flag_d = ctrl_i.step ? hit_o : flag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= 1'b0;
    end else begin
      flag_q <= flag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.pat_we) begin
      pat_q <= pat_i;
    end
    if (ctrl_i.step) begin
      txt_q <= txt_i;
    end
  end

  assign txt_o  = txt_q;
  assign flag_o = flag_q;

endmodule

// ===== rtl/case_insensitive_pattern_matcher_top.sv =====
// Channel | Dir | Handshake                | Beat
// --------+-----+--------------------------+------------------------------------
// in      | in  | in_valid_i / in_ready_o  | in_data_i  (kind, slot, byte, restart)
// out     | out | out_valid_o / out_ready_i| out_data_o (match_start, count)
// cfg     | in  | cfg_valid_i / cfg_ready_o| cfg_data_i (pattern_length)
//
// A match is registered and shown the cycle after its text beat, while the
// next beat may already be taken.
// A pattern write marks the match flags stale; the next text beat without
// restart first waits for a rebuild: the state machine leaves ST_IDLE for
// ST_REPLAY, where the history line rotates once through the cells.
// Reset clears flags, position and count.
// A result held by out_ready_i low stalls further input beats.
module case_insensitive_pattern_matcher_top import cipm_pkg::*; #(
  parameter int unsigned MAX_PATTERN = MaxPatternDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  in_item_t        in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output out_item_t       out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [LenW-1:0] cfg_data_i
);

  localparam int unsigned AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam logic [AW-1:0] AgeTop = AW'(MAX_PATTERN - 1);

  state_e          state_q, state_d;
  logic [AW-1:0]   age_q, age_d;
  logic            stale_q, stale_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] cnt_q, cnt_d;
  logic [LenW-1:0] len_q;
  logic            out_valid_q;
  out_item_t       out_data_q;

  logic [ByteW-1:0] txt     [MAX_PATTERN];
  logic [ByteW-1:0] txt_in  [MAX_PATTERN];
  logic             flag    [MAX_PATTERN];
  logic             flag_in [MAX_PATTERN];
  cell_ctrl_t       ctrl    [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] hit_vec;

  logic            replay, need_replay, in_ready;
  logic            in_fire, text_fire, load_fire;
  logic [ByteW-1:0] fold_byte, bcast;
  logic            step, inject, chain_clr, hit;
  logic [AW-1:0]   lenm1;
  logic [PosW-1:0] idx, base_cnt, cnt_inc, match_start;

  assign replay      = (state_q == ST_REPLAY);
  assign need_replay = in_valid_i & (in_data_i.kind == KindText) &
                       ~in_data_i.restart & stale_q;
  assign in_ready    = (state_q == ST_IDLE) & ~need_replay &
                       (~out_valid_q | out_ready_i);
  assign in_fire     = in_valid_i & in_ready;
  assign text_fire   = in_fire & (in_data_i.kind == KindText);
  assign load_fire   = in_fire & (in_data_i.kind == KindPattern);

  assign fold_byte = fold_upper(in_data_i.byte_value);
  // during a rebuild the oldest byte leaves the tail and re-enters at the head
  assign bcast     = replay ? txt[MAX_PATTERN-1] : fold_byte;
  assign step      = text_fire | replay;
  assign inject    = replay ? (PosW'(age_q) < pos_q) : 1'b1;
  assign chain_clr = replay ? (age_q == AgeTop) : in_data_i.restart;

  always_comb begin
    if (len_q == '0) begin
      lenm1 = '0;
    end else if (32'(len_q) > MAX_PATTERN) begin
      lenm1 = AgeTop;
    end else begin
      lenm1 = AW'(len_q - LenW'(1));
    end
  end

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign txt_in[k]  = bcast;
      assign flag_in[k] = inject;
    end else begin : g_body
      assign txt_in[k]  = txt[k-1];
      assign flag_in[k] = flag[k-1] & ~chain_clr;
    end
    assign ctrl[k].step   = step;
    assign ctrl[k].pat_we = load_fire & (32'(in_data_i.slot) == k);

    cipm_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl[k]),
      .txt_i  (txt_in[k]),
      .cmp_i  (bcast),
      .pat_i  (fold_byte),
      .flag_i (flag_in[k]),
      .txt_o  (txt[k]),
      .flag_o (flag[k]),
      .hit_o  (hit_vec[k])
    );
  end

  assign hit         = text_fire & hit_vec[lenm1];
  assign idx         = in_data_i.restart ? '0 : pos_q;
  assign base_cnt    = in_data_i.restart ? '0 : cnt_q;
  assign cnt_inc     = (base_cnt == PosMax) ? base_cnt : base_cnt + PosW'(1);
  assign match_start = idx - PosW'(lenm1);

  always_comb begin
    pos_d = pos_q;
    cnt_d = cnt_q;
    if (text_fire) begin
      pos_d = (idx == PosMax) ? idx : idx + PosW'(1);
      cnt_d = hit ? cnt_inc : base_cnt;
    end
  end

  always_comb begin
    state_d = state_q;
    age_d   = age_q;
    stale_d = stale_q;
    if (load_fire) begin
      stale_d = 1'b1;
    end else if (text_fire && in_data_i.restart) begin
      stale_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (need_replay) begin
          state_d = ST_REPLAY;
          age_d   = AgeTop;
        end
      end
      ST_REPLAY: begin
        if (age_q == '0) begin
          state_d = ST_IDLE;
          stale_d = 1'b0;
        end else begin
          age_d = age_q - AW'(1);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      age_q       <= '0;
      stale_q     <= 1'b0;
      pos_q       <= '0;
      cnt_q       <= '0;
      len_q       <= LenRst;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      age_q   <= age_d;
      stale_q <= stale_d;
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
      if (cfg_valid_i) begin
        len_q <= cfg_data_i;
      end
      if (hit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (hit) begin
      out_data_q.match_start      <= match_start;
      out_data_q.occurrence_count <= cnt_inc;
    end
  end

  assign in_ready_o  = in_ready;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign cfg_ready_o = 1'b1;

endmodule

// ===== rtl/cipm_checker.sv =====
`include "case_insensitive_pattern_matcher_top_assert.svh"

module cipm_checker import cipm_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o,
  input logic      cfg_valid_i,
  input logic      cfg_ready_o
);

  logic in_beat, out_stall;

  assign in_beat   = in_valid_i && in_ready_o;
  assign out_stall = out_valid_o && !out_ready_i;

  // a stalled result beat holds
  `CIPM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o)
  `CIPM_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_stall, $stable(out_data_o))

  // no fresh result without an input beat taken the cycle before
  `CIPM_ASSERT_NEXT(a_no_spurious, clk_i, rst_ni, !out_stall && !in_beat, !out_valid_o)

  // input is held off while a result waits
  `CIPM_ASSERT_IMPL(a_in_block, clk_i, rst_ni, out_stall, !in_ready_o)

  `CIPM_ASSERT_IMPL(a_cfg_open, clk_i, rst_ni, cfg_valid_i, cfg_ready_o)

endmodule

bind case_insensitive_pattern_matcher_top cipm_checker u_cipm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import cipm_pkg::*;

  localparam int unsigned MAX_PAT   = MaxPatternDef;
  localparam int          N_ITEMS   = 1650;
  localparam int          CYC_LIMIT = 400000;
  // worst case: pattern replay plus pipeline margin
  localparam int          SETTLE    = MAX_PAT + 8;

  typedef enum logic [1:0] {
    ROW_PRED,
    ROW_NONE,
    ROW_HIT
  } row_chk_e;

  typedef struct packed {
    in_item_t  item;
    row_chk_e  chk;
    out_item_t want;
  } dir_row_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  in_item_t        in_data = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  out_item_t       out_data;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [LenW-1:0] cfg_data = '0;

  // predictor state
  logic [ByteW-1:0] pat_mem [MAX_PAT];
  logic [ByteW-1:0] hist    [MAX_PAT];
  logic [PosW-1:0]  txt_pos  = '0;
  logic [PosW-1:0]  hit_cnt  = '0;
  logic [LenW-1:0]  len_reg  = LenRst;

  out_item_t match_q [$];
  int        err_cnt    = 0;
  int        cyc        = 0;
  int        idle_mode  = 1;
  int        stall_left = 0;

  case_insensitive_pattern_matcher_top #(
    .MAX_PATTERN(MAX_PAT)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic flag_error(input string msg);
    $display("[%0t] ERROR: %s", $realtime, msg);
    err_cnt++;
  endtask

  function automatic logic [ByteW-1:0] to_upper(input logic [ByteW-1:0] c);
    if (c >= 8'h61 && c <= 8'h7A) begin
      return c & 8'hDF;
    end
    return c;
  endfunction

  // letters come back in either case
  function automatic logic [ByteW-1:0] vary_case(input logic [ByteW-1:0] c);
    if (c >= 8'h41 && c <= 8'h5A && $urandom_range(0, 1) == 1) begin
      return c | 8'h20;
    end
    return c;
  endfunction

  // mostly a narrow alphabet so that hits are common, now and then any byte
  function automatic logic [ByteW-1:0] rand_char(input int alpha);
    if ($urandom_range(0, 9) == 0) begin
      return ByteW'($urandom_range(0, 255));
    end
    return vary_case(ByteW'(8'h41 + $urandom_range(0, alpha - 1)));
  endfunction

  function automatic dir_row_t mk_row(input logic k, input logic [SlotW-1:0] s,
                                      input logic [ByteW-1:0] b, input logic r,
                                      input row_chk_e c, input logic [PosW-1:0] st,
                                      input logic [PosW-1:0] n);
    dir_row_t row;
    row.item.kind              = k;
    row.item.slot              = s;
    row.item.byte_value        = b;
    row.item.restart           = r;
    row.chk                    = c;
    row.want.match_start       = st;
    row.want.occurrence_count  = n;
    return row;
  endfunction

  // One accepted beat through the predictor.
  task automatic scan_byte(input in_item_t it, output logic hit, output out_item_t res);
    logic [ByteW-1:0] fb;
    logic [PosW-1:0]  idx;
    int               len;
    fb  = to_upper(it.byte_value);
    hit = 1'b0;
    res = '0;
    if (it.kind == KindPattern) begin
      pat_mem[it.slot] = fb;
      return;
    end
    if (it.restart) begin
      for (int i = 0; i < MAX_PAT; i++) hist[i] = '0;
      txt_pos = '0;
      hit_cnt = '0;
    end
    for (int i = MAX_PAT - 1; i > 0; i--) hist[i] = hist[i-1];
    hist[0] = fb;
    len = int'(len_reg);
    if (len == 0) len = 1;
    if (len > MAX_PAT) len = MAX_PAT;
    idx = txt_pos;
    if (txt_pos != PosMax) txt_pos = txt_pos + 1'b1;
    if ({1'b0, idx} + 33'd1 < 33'(len)) return;
    hit = 1'b1;
    for (int j = 0; j < len; j++) begin
      if (hist[len-1-j] != pat_mem[j]) hit = 1'b0;
    end
    if (!hit) return;
    if (hit_cnt != PosMax) hit_cnt = hit_cnt + 1'b1;
    res.match_start      = idx - PosW'(len - 1);
    res.occurrence_count = hit_cnt;
  endtask

  task automatic push_beat(input in_item_t it, input row_chk_e chk, input out_item_t want);
    logic      hit;
    out_item_t res;
    if (idle_mode != 0 && $urandom_range(0, idle_mode == 1 ? 11 : 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    scan_byte(it, hit, res);
    case (chk)
      ROW_PRED: if (hit) match_q.push_back(res);
      ROW_HIT:  match_q.push_back(want);
      default: ;
    endcase
  endtask

  task automatic push_text(input logic [ByteW-1:0] b, input logic r);
    in_item_t it;
    it.kind       = KindText;
    it.slot       = SlotW'($urandom_range(0, 63));
    it.byte_value = b;
    it.restart    = r;
    push_beat(it, ROW_PRED, '0);
  endtask

  // only while idle: drain results, let any replay finish, then write
  task automatic write_length(input logic [LenW-1:0] v);
    in_valid <= 1'b0;
    while (match_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    len_reg = v;
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (idle_mode != 0 && $urandom_range(0, idle_mode == 1 ? 11 : 2) == 0) begin
      stall_left <= $urandom_range(0, 13);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_mon
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (match_q.size() == 0) begin
        flag_error($sformatf("unexpected beat start=%0d count=%0d",
                             out_data.match_start, out_data.occurrence_count));
      end else begin
        want = match_q.pop_front();
        if (out_data.match_start !== want.match_start) begin
          flag_error($sformatf("match_start %0d, wanted %0d",
                               out_data.match_start, want.match_start));
        end
        if (out_data.occurrence_count !== want.occurrence_count) begin
          flag_error($sformatf("occurrence_count %0d, wanted %0d",
                               out_data.occurrence_count, want.occurrence_count));
        end
      end
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYC_LIMIT) begin
      $display("case_insensitive_pattern_matcher_top: mismatch");
      $finish;
    end
  end

  initial begin : stim
    dir_row_t         dir_tab [$];
    in_item_t         it;
    logic [LenW-1:0]  cfg_v;
    logic [ByteW-1:0] pat_b [MAX_PAT];
    int               eff_len, n_txt, alpha, phase, sent, k, r;
    logic             first;

    for (int i = 0; i < MAX_PAT; i++) begin
      pat_mem[i] = '0;
      hist[i]    = '0;
      pat_b[i]   = '0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // length 1 from reset: case folding edges and restart
    dir_tab.push_back(mk_row(KindPattern, 6'd0,  8'h71, 1'b1, ROW_NONE, 0, 0));
    dir_tab.push_back(mk_row(KindText,    6'd63, 8'h51, 1'b1, ROW_HIT,  0, 1));
    dir_tab.push_back(mk_row(KindText,    6'd0,  8'h71, 1'b0, ROW_HIT,  1, 2));
    dir_tab.push_back(mk_row(KindText,    6'd63, 8'h72, 1'b0, ROW_NONE, 0, 0));
    dir_tab.push_back(mk_row(KindText,    6'd0,  8'h71, 1'b1, ROW_HIT,  0, 1));
    dir_tab.push_back(mk_row(KindPattern, 6'd0,  8'h60, 1'b0, ROW_NONE, 0, 0));
    dir_tab.push_back(mk_row(KindText,    6'd63, 8'h40, 1'b0, ROW_PRED, 0, 0));
    dir_tab.push_back(mk_row(KindText,    6'd0,  8'h60, 1'b0, ROW_HIT,  2, 2));
    dir_tab.push_back(mk_row(KindPattern, 6'd0,  8'h7B, 1'b0, ROW_NONE, 0, 0));
    dir_tab.push_back(mk_row(KindText,    6'd63, 8'h5B, 1'b0, ROW_PRED, 0, 0));
    dir_tab.push_back(mk_row(KindText,    6'd0,  8'h7B, 1'b0, ROW_HIT,  4, 3));
    dir_tab.push_back(mk_row(KindPattern, 6'd0,  8'h61, 1'b0, ROW_NONE, 0, 0));
    dir_tab.push_back(mk_row(KindText,    6'd63, 8'h41, 1'b1, ROW_HIT,  0, 1));
    dir_tab.push_back(mk_row(KindText,    6'd0,  8'h61, 1'b0, ROW_HIT,  1, 2));
    dir_tab.push_back(mk_row(KindText,    6'd63, 8'h7A, 1'b0, ROW_NONE, 0, 0));
    dir_tab.push_back(mk_row(KindPattern, 6'd0,  8'h7A, 1'b0, ROW_NONE, 0, 0));
    dir_tab.push_back(mk_row(KindText,    6'd0,  8'h5A, 1'b0, ROW_HIT,  3, 3));
    dir_tab.push_back(mk_row(KindText,    6'd63, 8'h7A, 1'b0, ROW_HIT,  4, 4));
    dir_tab.push_back(mk_row(KindPattern, 6'd63, 8'hFF, 1'b0, ROW_NONE, 0, 0));
    dir_tab.push_back(mk_row(KindPattern, 6'd0,  8'h00, 1'b1, ROW_NONE, 0, 0));
    dir_tab.push_back(mk_row(KindText,    6'd0,  8'h00, 1'b0, ROW_HIT,  5, 5));
    dir_tab.push_back(mk_row(KindText,    6'd63, 8'hFF, 1'b0, ROW_PRED, 0, 0));
    dir_tab.push_back(mk_row(KindPattern, 6'd0,  8'hFF, 1'b0, ROW_NONE, 0, 0));
    dir_tab.push_back(mk_row(KindText,    6'd0,  8'hFF, 1'b1, ROW_HIT,  0, 1));
    dir_tab.push_back(mk_row(KindText,    6'd63, 8'h80, 1'b0, ROW_PRED, 0, 0));
    foreach (dir_tab[i]) push_beat(dir_tab[i].item, dir_tab[i].chk, dir_tab[i].want);

    sent  = 0;
    phase = 0;
    while (sent < N_ITEMS) begin
      if (sent > N_ITEMS * 17 / 20) idle_mode = 0;
      else idle_mode = $urandom_range(0, 2);
      case (phase)
        0: cfg_v = 7'd64;
        1: cfg_v = 7'd0;
        2: cfg_v = 7'd127;
        3: cfg_v = 7'd1;
        default: begin
          r = $urandom_range(0, 19);
          if (r == 0)      cfg_v = LenW'($urandom_range(65, 127));
          else if (r == 1) cfg_v = 7'd0;
          else if (r == 2) cfg_v = LenW'($urandom_range(21, 64));
          else if (r < 6)  cfg_v = LenW'($urandom_range(7, 20));
          else             cfg_v = LenW'($urandom_range(1, 6));
        end
      endcase
      write_length(cfg_v);
      eff_len = (cfg_v == 0) ? 1 : ((cfg_v > MAX_PAT) ? MAX_PAT : int'(cfg_v));
      alpha   = $urandom_range(1, 4);

      // every slot in use is loaded before any text beat reads it
      for (int j = 0; j < eff_len; j++) begin
        pat_b[j]      = to_upper(rand_char(alpha));
        it.kind       = KindPattern;
        it.slot       = SlotW'(j);
        it.byte_value = vary_case(pat_b[j]);
        it.restart    = 1'($urandom_range(0, 1));
        push_beat(it, ROW_PRED, '0);
        sent++;
      end

      // now and then carry on with the old text under the new length
      first = ($urandom_range(0, 3) != 0);
      n_txt = $urandom_range(8, 40) + 2 * eff_len;
      k = 0;
      while (k < n_txt) begin
        r = $urandom_range(0, 99);
        if (r < 30) begin
          for (int j = 0; j < eff_len; j++) begin
            push_text(vary_case(pat_b[j]), first);
            first = 1'b0;
            k++;
            sent++;
          end
        end else if (r < 31) begin
          it.kind       = KindPattern;
          it.slot       = SlotW'($urandom_range(0, 63));
          it.byte_value = ByteW'($urandom_range(0, 255));
          it.restart    = 1'($urandom_range(0, 1));
          pat_b[it.slot] = to_upper(it.byte_value);
          push_beat(it, ROW_PRED, '0);
          sent++;
        end else if (r < 32) begin
          push_text(rand_char(alpha), 1'b1);
          first = 1'b0;
          k++;
          sent++;
        end else begin
          push_text(rand_char(alpha), first);
          first = 1'b0;
          k++;
          sent++;
        end
      end
      phase++;
    end

    in_valid <= 1'b0;
    while (match_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (err_cnt == 0) begin
      $display("case_insensitive_pattern_matcher_top: match");
    end else begin
      $display("case_insensitive_pattern_matcher_top: mismatch");
    end
    $finish;
  end

endmodule
